>>> hdl/gpfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad poll frame decoder package
// Shared constants, request and result types for the poll frame decoder.
// ----------------------------------------------------------------------------
package gpfd_pkg;

   // Frame geometry
   localparam int POS_W        = 4;
   localparam int FRAME_LAST   = 8;   // position of the ninth byte
   localparam int FIRST_STORED = 3;   // first byte kept in the store
   localparam int STORE_DEPTH  = 5;   // bytes 3..7; byte 8 is used as it arrives
   localparam int AXIS_COUNT   = 4;
   localparam int AXIS_W       = 10;
   localparam int MASK_W       = 16;

   // Command bytes sent in the next exchange
   localparam logic [7:0] CMD_START = 8'h01;
   localparam logic [7:0] CMD_POLL  = 8'h42;
   localparam logic [7:0] CMD_IDLE  = 8'h00;

   // Axis scaling: (b * 1000) / 255 as one constant multiply and a shift.
   // 1000 * ceil(2^26 / 255) = 263173000; exact for every byte value.
   localparam int          SCALE_PROD_W = 36;
   localparam int          SCALE_SHIFT  = 26;
   localparam logic [27:0] SCALE_MULT   = 28'd263173000;

   // Center deadband
   localparam logic [AXIS_W-1:0] AXIS_CENTER = 10'd500;
   localparam logic [AXIS_W-1:0] DEAD_HI     = 10'd503;
   localparam logic [AXIS_W-1:0] DEAD_LO     = 10'd497;

   typedef logic [POS_W-1:0]  pos_type;
   typedef logic [AXIS_W-1:0] axis_type;

   // One request as held in the input register
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } item_type;

   // One result as held in the output register
   typedef struct packed {
      logic [7:0]        next_command;
      logic              frame_done;
      axis_type          stick_right_x;
      axis_type          stick_right_y;
      axis_type          stick_left_x;
      axis_type          stick_left_y;
      logic [MASK_W-1:0] pressed_mask;
   } result_type;

endpackage

>>> hdl/gpfd_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one received controller byte per request.
// ----------------------------------------------------------------------------
interface gpfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

>>> hdl/gpfd_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the next command and the decoded frame values.
// ----------------------------------------------------------------------------
interface gpfd_rsp_if
   import gpfd_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [7:0]        next_command;
   logic              frame_done;
   axis_type          stick_right_x;
   axis_type          stick_right_y;
   axis_type          stick_left_x;
   axis_type          stick_left_y;
   logic [MASK_W-1:0] pressed_mask;

   modport source (output valid, output next_command, output frame_done,
                   output stick_right_x, output stick_right_y,
                   output stick_left_x, output stick_left_y,
                   output pressed_mask, input ready);
   modport sink   (input valid, input next_command, input frame_done,
                   input stick_right_x, input stick_right_y,
                   input stick_left_x, input stick_left_y,
                   input pressed_mask, output ready);
endinterface

>>> hdl/gpfd_axis_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis scaler
// Maps a raw stick byte to 0..1000 and snaps values near center to 500.
// ----------------------------------------------------------------------------
module gpfd_axis_scale
   import gpfd_pkg::*;
(
   input  logic [7:0] raw_byte,
   output axis_type   axis_value
);

   logic [SCALE_PROD_W-1:0] product;
   axis_type                scaled;

   // Multiply by the folded reciprocal; the top bits are the quotient.
   assign product = SCALE_PROD_W'(raw_byte) * SCALE_PROD_W'(SCALE_MULT);
   assign scaled  = product[SCALE_SHIFT +: AXIS_W];

   // Values 498 through 502 read as exact center.
   assign axis_value = (scaled > DEAD_LO && scaled < DEAD_HI) ? AXIS_CENTER : scaled;

endmodule

>>> hdl/gpfd_frame_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame state
// Byte position counter, stored frame bytes and decoded values. Builds the
// result for the request in the input register and updates on advance.
// ----------------------------------------------------------------------------
module gpfd_frame_state
   import gpfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  item_type   item,
   output result_type result
);

   pos_type           pos_ff, pos_in;
   pos_type           cur_pos;
   logic              done;
   logic [7:0]        next_cmd;
   logic [7:0]        store_ff [STORE_DEPTH];
   logic [7:0]        axis_src [AXIS_COUNT];
   axis_type          axis_new [AXIS_COUNT];
   axis_type          axis_ff  [AXIS_COUNT];
   axis_type          axis_in  [AXIS_COUNT];
   logic [MASK_W-1:0] mask_ff, mask_in;

   // Position of this byte: a frame start or an out-of-range count restarts.
   always_comb begin
      cur_pos = item.frame_start ? '0 : pos_ff;
      if (cur_pos > POS_W'(FRAME_LAST)) begin
         cur_pos = '0;
      end
   end

   assign done   = (cur_pos == POS_W'(FRAME_LAST));
   assign pos_in = done ? '0 : cur_pos + POS_W'(1);

   // Axis sources: bytes 5..7 from the store, byte 8 straight from the request.
   assign axis_src[0] = store_ff[2];
   assign axis_src[1] = store_ff[3];
   assign axis_src[2] = store_ff[4];
   assign axis_src[3] = item.rx_byte;

   for (genvar k = 0; k < AXIS_COUNT; k++) begin : g_axis
      gpfd_axis_scale u_scale (
         .raw_byte   (axis_src[k]),
         .axis_value (axis_new[k])
      );
      assign axis_in[k] = done ? axis_new[k] : axis_ff[k];
   end

   // Buttons are active low; byte 3 fills the upper half.
   assign mask_in = done ? ~{store_ff[0], store_ff[1]} : mask_ff;

   // Command for the next exchange
   always_comb begin
      unique case (pos_in)
         POS_W'(0): next_cmd = CMD_START;
         POS_W'(1): next_cmd = CMD_POLL;
         default:   next_cmd = CMD_IDLE;
      endcase
   end

   assign result.next_command  = next_cmd;
   assign result.frame_done    = done;
   assign result.stick_right_x = axis_in[0];
   assign result.stick_right_y = axis_in[1];
   assign result.stick_left_x  = axis_in[2];
   assign result.stick_left_y  = axis_in[3];
   assign result.pressed_mask  = mask_in;

   // Control and decoded state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         mask_ff <= '0;
         for (int k = 0; k < AXIS_COUNT; k++) begin
            axis_ff[k] <= AXIS_CENTER;
         end
      end else if (advance) begin
         pos_ff  <= pos_in;
         mask_ff <= mask_in;
         for (int k = 0; k < AXIS_COUNT; k++) begin
            axis_ff[k] <= axis_in[k];
         end
      end
   end

   // Frame byte store, written at the position of each byte from 3 to 7.
   always_ff @(posedge clock) begin
      for (int k = 0; k < STORE_DEPTH; k++) begin
         if (advance && cur_pos == POS_W'(FIRST_STORED + k)) begin
            store_ff[k] <= item.rx_byte;
         end
      end
   end

   // The counter never leaves the frame.
   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(FRAME_LAST))
      else $error("byte position beyond the last frame byte");

   // The last byte of a frame sends the counter back to the start.
   a_pos_wrap : assert property (@(posedge clock) disable iff (reset)
      advance && done |=> pos_ff == '0)
      else $error("byte position did not wrap after the last byte");

   // A finished frame always asks for a new frame start.
   a_done_cmd : assert property (@(posedge clock) disable iff (reset)
      result.frame_done |-> result.next_command == CMD_START)
      else $error("finished frame did not request a new start");

   // Decoded axes stay on the 0..1000 scale.
   a_axis_range : assert property (@(posedge clock) disable iff (reset)
      axis_ff[0] <= 10'd1000 && axis_ff[1] <= 10'd1000 &&
      axis_ff[2] <= 10'd1000 && axis_ff[3] <= 10'd1000)
      else $error("decoded axis beyond full scale");

endmodule

>>> hdl/gamepad_poll_frame_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gamepad poll frame decoder
// Takes one received byte of a nine-byte poll frame per request and returns
// the next command byte together with the decoded buttons and stick axes.
//
//   channel  direction  handshake      payload
//   req_ch   in         valid / ready  rx_byte, frame_start
//   rsp_ch   out        valid / ready  next_command, frame_done, four axes,
//                                      pressed_mask
//
// One request per cycle is taken while the result side does not stall; an
// accepted request is held in the input register, then the result register
// takes its result, which stays valid on rsp_ch until it is taken.
// All decoding sits between the input register and the result register.
// Synchronous reset clears the byte position, sets the axes to 500 and the
// button mask to 0, and empties both registers; the byte store is not reset.
// A stalled result holds the input register, which keeps taking requests
// while the result register is free or being emptied.
// ----------------------------------------------------------------------------
module gamepad_poll_frame_decoder_unit
   import gpfd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   gpfd_req_if.sink   req_ch,
   gpfd_rsp_if.source rsp_ch
);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_result_ff;
   result_type result;
   logic       out_free;
   logic       advance;
   logic       accept;

   // Handshake: the input register moves on when the result register is free.
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign accept       = req_ch.valid && req_ch.ready;

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_item_ff.rx_byte     <= req_ch.rx_byte;
         in_item_ff.frame_start <= req_ch.frame_start;
      end
   end

   // Decoder state and result logic
   gpfd_frame_state u_state (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= result;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.next_command  = out_result_ff.next_command;
   assign rsp_ch.frame_done    = out_result_ff.frame_done;
   assign rsp_ch.stick_right_x = out_result_ff.stick_right_x;
   assign rsp_ch.stick_right_y = out_result_ff.stick_right_y;
   assign rsp_ch.stick_left_x  = out_result_ff.stick_left_x;
   assign rsp_ch.stick_left_y  = out_result_ff.stick_left_y;
   assign rsp_ch.pressed_mask  = out_result_ff.pressed_mask;

   // A held request is not lost while the result side stalls.
   a_hold_stall : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff)
      else $error("held request dropped during result stall");

   // A pending result is only replaced once it has been taken.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |-> !advance)
      else $error("result register overwritten while stalled");

   // A request accepted into a full input register must coincide with advance.
   a_accept_full : assert property (@(posedge clock) disable iff (reset)
      accept && in_valid_ff |-> advance)
      else $error("request accepted over a held request");

endmodule
